@@ hw/rtl/mcg_pkg.sv @@
// Shared constants, types and pattern tables of the midpoint circle generator.
package mcg_pkg;

  localparam int COORD_BITS_DEF  = 16;
  localparam int RADIUS_BITS_DEF = 14;
  localparam int JOB_QUEUE_DEPTH = 2;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  // Control part of one queued job.
  typedef struct packed {
    logic start;
    logic fill;
    logic done;
  } job_ctl_t;

  localparam int JOB_CTL_BITS = $bits(job_ctl_t);

  // How one result is formed from the center and the two offsets a and b.
  // With swap clear a is the x offset and b the y offset; with swap set they trade.
  typedef struct packed {
    logic swap;
    logic xs_neg;
    logic ys_neg;
    logic xe_neg;
    logic ye_neg;
  } pat_t;

  localparam logic [2:0] LAST_START_FILL = 3'd1;
  localparam logic [2:0] LAST_START_LINE = 3'd3;
  localparam logic [2:0] LAST_STEP_FILL  = 3'd3;
  localparam logic [2:0] LAST_STEP_LINE  = 3'd7;

  function automatic logic [2:0] last_index(input logic start, input logic fill);
    logic [2:0] idx;
    if (start) begin
      idx = fill ? LAST_START_FILL : LAST_START_LINE;
    end else begin
      idx = fill ? LAST_STEP_FILL : LAST_STEP_LINE;
    end
    return idx;
  endfunction

  function automatic pat_t pattern(input logic start, input logic fill, input logic [2:0] k);
    pat_t p;
    p = '0;
    if (start && fill) begin
      case (k)
        3'd0:    p = '{swap: 1'b0, xs_neg: 1'b0, ys_neg: 1'b0, xe_neg: 1'b1, ye_neg: 1'b0};
        default: p = '{swap: 1'b1, xs_neg: 1'b0, ys_neg: 1'b0, xe_neg: 1'b0, ye_neg: 1'b1};
      endcase
    end else if (start) begin
      case (k)
        3'd0:    p = '{swap: 1'b0, xs_neg: 1'b0, ys_neg: 1'b0, xe_neg: 1'b0, ye_neg: 1'b0};
        3'd1:    p = '{swap: 1'b0, xs_neg: 1'b1, ys_neg: 1'b0, xe_neg: 1'b1, ye_neg: 1'b0};
        3'd2:    p = '{swap: 1'b1, xs_neg: 1'b0, ys_neg: 1'b0, xe_neg: 1'b0, ye_neg: 1'b0};
        default: p = '{swap: 1'b1, xs_neg: 1'b0, ys_neg: 1'b1, xe_neg: 1'b0, ye_neg: 1'b1};
      endcase
    end else if (fill) begin
      case (k)
        3'd0:    p = '{swap: 1'b0, xs_neg: 1'b0, ys_neg: 1'b0, xe_neg: 1'b1, ye_neg: 1'b0};
        3'd1:    p = '{swap: 1'b0, xs_neg: 1'b0, ys_neg: 1'b1, xe_neg: 1'b1, ye_neg: 1'b1};
        3'd2:    p = '{swap: 1'b1, xs_neg: 1'b1, ys_neg: 1'b1, xe_neg: 1'b0, ye_neg: 1'b1};
        default: p = '{swap: 1'b1, xs_neg: 1'b1, ys_neg: 1'b0, xe_neg: 1'b0, ye_neg: 1'b0};
      endcase
    end else begin
      case (k)
        3'd0:    p = '{swap: 1'b0, xs_neg: 1'b0, ys_neg: 1'b0, xe_neg: 1'b0, ye_neg: 1'b0};
        3'd1:    p = '{swap: 1'b0, xs_neg: 1'b1, ys_neg: 1'b0, xe_neg: 1'b1, ye_neg: 1'b0};
        3'd2:    p = '{swap: 1'b0, xs_neg: 1'b0, ys_neg: 1'b1, xe_neg: 1'b0, ye_neg: 1'b1};
        3'd3:    p = '{swap: 1'b0, xs_neg: 1'b1, ys_neg: 1'b1, xe_neg: 1'b1, ye_neg: 1'b1};
        3'd4:    p = '{swap: 1'b1, xs_neg: 1'b1, ys_neg: 1'b1, xe_neg: 1'b1, ye_neg: 1'b1};
        3'd5:    p = '{swap: 1'b1, xs_neg: 1'b0, ys_neg: 1'b1, xe_neg: 1'b0, ye_neg: 1'b1};
        3'd6:    p = '{swap: 1'b1, xs_neg: 1'b1, ys_neg: 1'b0, xe_neg: 1'b1, ye_neg: 1'b0};
        default: p = '{swap: 1'b1, xs_neg: 1'b0, ys_neg: 1'b0, xe_neg: 1'b0, ye_neg: 1'b0};
      endcase
    end
    return p;
  endfunction

endpackage

@@ hw/rtl/mcg_in_if.sv @@
// Command channel of the midpoint circle generator.
interface mcg_in_if #(
  parameter int COORD_BITS  = 16,
  parameter int RADIUS_BITS = 14
);
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic signed [COORD_BITS-1:0]  center_x;
  logic signed [COORD_BITS-1:0]  center_y;
  logic        [RADIUS_BITS-1:0] radius;
  logic                          fill;

  modport source (output valid, action, center_x, center_y, radius, fill, input ready);
  modport sink   (input valid, action, center_x, center_y, radius, fill, output ready);
endinterface

@@ hw/rtl/mcg_out_if.sv @@
// Result channel of the midpoint circle generator.
interface mcg_out_if #(
  parameter int COORD_BITS = 16
);
  logic                       valid;
  logic                       ready;
  logic signed [COORD_BITS:0] x_start;
  logic signed [COORD_BITS:0] y_start;
  logic signed [COORD_BITS:0] x_end;
  logic signed [COORD_BITS:0] y_end;
  logic                       last_of_item;
  logic                       circle_done;

  modport source (output valid, x_start, y_start, x_end, y_end, last_of_item, circle_done,
                  input ready);
  modport sink   (input valid, x_start, y_start, x_end, y_end, last_of_item, circle_done,
                  output ready);
endinterface

@@ hw/rtl/mcg_front.sv @@
// Front end: accepts commands, runs the midpoint decision update and queues jobs.
module mcg_front #(
  parameter int COORD_BITS  = 16,
  parameter int RADIUS_BITS = 14
) (
  input  logic                   clk,
  input  logic                   rst,
  mcg_in_if.sink                 cmd,
  input  logic                   queue_full,
  output logic                   push,
  output mcg_pkg::job_ctl_t      job_ctl,
  output logic [COORD_BITS-1:0]  job_cx,
  output logic [COORD_BITS-1:0]  job_cy,
  output logic [RADIUS_BITS-1:0] job_a,
  output logic [RADIUS_BITS-1:0] job_b
);
  import mcg_pkg::*;

  localparam int DEC_BITS   = RADIUS_BITS + 4;
  localparam int DELTA_BITS = RADIUS_BITS + 3;

  logic                         active;
  logic                         fill_mode;
  logic [COORD_BITS-1:0]        center_x_reg;
  logic [COORD_BITS-1:0]        center_y_reg;
  logic [RADIUS_BITS-1:0]       step_x;
  logic [RADIUS_BITS-1:0]       step_y;
  logic signed [DEC_BITS-1:0]   decision;
  logic signed [DELTA_BITS-1:0] delta_x;
  logic signed [DELTA_BITS-1:0] delta_y;

  logic                         accept;
  logic                         is_start;
  logic                         dec_pos;
  logic [RADIUS_BITS-1:0]       step_x_next;
  logic [RADIUS_BITS-1:0]       step_y_next;
  logic signed [DELTA_BITS-1:0] delta_x_next;
  logic signed [DELTA_BITS-1:0] delta_y_next;
  logic signed [DEC_BITS-1:0]   decision_next;
  logic signed [DEC_BITS-1:0]   dy_term;
  logic signed [DEC_BITS-1:0]   r_ext;
  logic                         step_done;
  logic                         radius_zero;

  assign cmd.ready = !queue_full;
  assign accept    = cmd.valid && cmd.ready;
  assign is_start  = (cmd.action == ACT_START);

  assign dec_pos      = (decision > 0);
  assign step_x_next  = step_x + 1'b1;
  assign step_y_next  = dec_pos ? step_y - 1'b1 : step_y;
  assign delta_x_next = delta_x + DELTA_BITS'(2);
  assign delta_y_next = dec_pos ? delta_y + DELTA_BITS'(2) : delta_y;
  assign dy_term      = dec_pos ? DEC_BITS'(delta_y_next) : '0;
  assign decision_next = decision + dy_term + DEC_BITS'(delta_x_next) + DEC_BITS'(1);
  assign step_done    = (step_x_next >= step_y_next);

  assign r_ext       = DEC_BITS'({1'b0, cmd.radius});
  assign radius_zero = (cmd.radius == '0);

  // A step with no circle running is swallowed without a job.
  assign push = accept && (is_start || active);

  always_comb begin
    job_ctl.start = is_start;
    job_ctl.fill  = is_start ? cmd.fill : fill_mode;
    job_ctl.done  = is_start ? radius_zero : step_done;
    job_cx        = is_start ? cmd.center_x : center_x_reg;
    job_cy        = is_start ? cmd.center_y : center_y_reg;
    job_a         = is_start ? cmd.radius : step_x_next;
    job_b         = is_start ? '0 : step_y_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      fill_mode    <= 1'b0;
      center_x_reg <= '0;
      center_y_reg <= '0;
      step_x       <= '0;
      step_y       <= '0;
      decision     <= '0;
      delta_x      <= '0;
      delta_y      <= '0;
    end else if (accept) begin
      if (is_start) begin
        active       <= !radius_zero;
        fill_mode    <= cmd.fill;
        center_x_reg <= cmd.center_x;
        center_y_reg <= cmd.center_y;
        step_x       <= '0;
        step_y       <= cmd.radius;
        decision     <= DEC_BITS'(1) - r_ext;
        delta_x      <= '0;
        delta_y      <= -DELTA_BITS'({1'b0, cmd.radius, 1'b0});
      end else if (active) begin
        active   <= !step_done;
        step_x   <= step_x_next;
        step_y   <= step_y_next;
        decision <= decision_next;
        delta_x  <= delta_x_next;
        delta_y  <= delta_y_next;
      end
    end
  end

endmodule

@@ hw/rtl/mcg_queue.sv @@
// Small flip-flop job queue between the front and back ends.
module mcg_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty,
  output logic             full
);
  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    entries [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CNT_BITS'(DEPTH));
  assign head  = entries[rd_ptr];

  function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
    logic [PTR_BITS-1:0] n;
    n = (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + 1'b1;
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop && !empty) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hw/rtl/mcg_back.sv @@
// Back end: expands each queued job into mirrored points or spans, one per cycle unless stalled.
module mcg_back #(
  parameter int COORD_BITS  = 16,
  parameter int RADIUS_BITS = 14
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   job_valid,
  input  mcg_pkg::job_ctl_t      job_ctl,
  input  logic [COORD_BITS-1:0]  job_cx,
  input  logic [COORD_BITS-1:0]  job_cy,
  input  logic [RADIUS_BITS-1:0] job_a,
  input  logic [RADIUS_BITS-1:0] job_b,
  output logic                   pop,
  mcg_out_if.source              pixel
);
  import mcg_pkg::*;

  localparam int SUM_BITS = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;

  logic [2:0]            k;
  logic                  load;
  logic                  is_last;
  pat_t                  pat;
  logic [SUM_BITS-1:0]   cx_ext;
  logic [SUM_BITS-1:0]   cy_ext;
  logic [SUM_BITS-1:0]   off_x;
  logic [SUM_BITS-1:0]   off_y;
  logic [SUM_BITS-1:0]   xs_sum;
  logic [SUM_BITS-1:0]   ys_sum;
  logic [SUM_BITS-1:0]   xe_sum;
  logic [SUM_BITS-1:0]   ye_sum;

  assign load    = job_valid && (!pixel.valid || pixel.ready);
  assign is_last = (k == last_index(job_ctl.start, job_ctl.fill));
  assign pop     = load && is_last;
  assign pat     = pattern(job_ctl.start, job_ctl.fill, k);

  assign cx_ext = {{(SUM_BITS-COORD_BITS){job_cx[COORD_BITS-1]}}, job_cx};
  assign cy_ext = {{(SUM_BITS-COORD_BITS){job_cy[COORD_BITS-1]}}, job_cy};
  assign off_x  = {{(SUM_BITS-RADIUS_BITS){1'b0}}, (pat.swap ? job_b : job_a)};
  assign off_y  = {{(SUM_BITS-RADIUS_BITS){1'b0}}, (pat.swap ? job_a : job_b)};

  assign xs_sum = pat.xs_neg ? cx_ext - off_x : cx_ext + off_x;
  assign ys_sum = pat.ys_neg ? cy_ext - off_y : cy_ext + off_y;
  assign xe_sum = pat.xe_neg ? cx_ext - off_x : cx_ext + off_x;
  assign ye_sum = pat.ye_neg ? cy_ext - off_y : cy_ext + off_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      k           <= '0;
      pixel.valid <= 1'b0;
    end else begin
      if (load) begin
        k           <= is_last ? '0 : k + 1'b1;
        pixel.valid <= 1'b1;
      end else if (pixel.ready) begin
        pixel.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pixel.x_start      <= xs_sum[COORD_BITS:0];
      pixel.y_start      <= ys_sum[COORD_BITS:0];
      pixel.x_end        <= xe_sum[COORD_BITS:0];
      pixel.y_end        <= ye_sum[COORD_BITS:0];
      pixel.last_of_item <= is_last;
      pixel.circle_done  <= job_ctl.done;
    end
  end

endmodule

@@ hw/rtl/midpoint_circle_generator.sv @@
// An item's first result passes the job queue, then the back end's output register.
// One result per cycle while the receiver is ready; a step item gives 8 results (4 in
// fill mode) and a start item 4 (2 in fill mode).
// Commands are taken every cycle while the two-entry job queue has room.
// Reset (synchronous, active high) clears the circle state, the queue and the output.
module midpoint_circle_generator #(
  parameter int COORD_BITS  = mcg_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = mcg_pkg::RADIUS_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  mcg_in_if.sink    cmd,
  mcg_out_if.source pixel
);
  import mcg_pkg::*;

  localparam int JOB_BITS = JOB_CTL_BITS + 2 * COORD_BITS + 2 * RADIUS_BITS;

  logic                   push;
  logic                   pop;
  logic                   q_full;
  logic                   q_empty;
  job_ctl_t               f_ctl;
  logic [COORD_BITS-1:0]  f_cx;
  logic [COORD_BITS-1:0]  f_cy;
  logic [RADIUS_BITS-1:0] f_a;
  logic [RADIUS_BITS-1:0] f_b;
  logic [JOB_BITS-1:0]    q_head;
  job_ctl_t               b_ctl;
  logic [COORD_BITS-1:0]  b_cx;
  logic [COORD_BITS-1:0]  b_cy;
  logic [RADIUS_BITS-1:0] b_a;
  logic [RADIUS_BITS-1:0] b_b;

  mcg_front #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .queue_full(q_full),
    .push      (push),
    .job_ctl   (f_ctl),
    .job_cx    (f_cx),
    .job_cy    (f_cy),
    .job_a     (f_a),
    .job_b     (f_b)
  );

  mcg_queue #(
    .WIDTH(JOB_BITS),
    .DEPTH(JOB_QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data({f_ctl, f_cx, f_cy, f_a, f_b}),
    .pop      (pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  assign {b_ctl, b_cx, b_cy, b_a, b_b} = q_head;

  mcg_back #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(!q_empty),
    .job_ctl  (b_ctl),
    .job_cx   (b_cx),
    .job_cy   (b_cy),
    .job_a    (b_a),
    .job_b    (b_b),
    .pop      (pop),
    .pixel    (pixel)
  );

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the midpoint circle generator with its own rasterizer.
module testbench;
  import mcg_pkg::*;

  localparam int CW          = COORD_BITS_DEF;
  localparam int RW          = RADIUS_BITS_DEF;
  localparam int ITEM_GOAL   = 370;
  localparam int STALL_LIMIT = 300;
  localparam int PRINT_LIMIT = 40;

  typedef struct {
    logic                 action;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic        [RW-1:0] r;
    logic                 fill;
  } cmd_t;

  typedef struct {
    logic signed [CW:0] xs;
    logic signed [CW:0] ys;
    logic signed [CW:0] xe;
    logic signed [CW:0] ye;
    logic               last;
    logic               done;
  } pix_t;

  // One directed command; where typed is set, n is the number of results it must cause
  // and the coordinates and done flag are those of its first result.
  typedef struct {
    logic action;
    int   cx;
    int   cy;
    int   r;
    logic fill;
    bit   typed;
    int   n;
    int   xs;
    int   ys;
    int   xe;
    int   ye;
    bit   done;
  } plan_row_t;

  localparam int PLAN_ROWS = 25;

  plan_row_t plan [PLAN_ROWS] = '{
    '{ACT_STEP,       0,      0,     0, 1'b0, 1'b1, 0,      0,      0,      0,      0, 1'b0},
    '{ACT_START,      0,      0,     0, 1'b0, 1'b1, 4,      0,      0,      0,      0, 1'b1},
    '{ACT_STEP,       5,      5,     5, 1'b1, 1'b1, 0,      0,      0,      0,      0, 1'b0},
    '{ACT_START, -32768, -32768,     0, 1'b1, 1'b1, 2, -32768, -32768, -32768, -32768, 1'b1},
    '{ACT_START,  32767, -32768, 16383, 1'b0, 1'b1, 4,  49150, -32768,  49150, -32768, 1'b0},
    '{ACT_STEP,      -1,     -1, 16383, 1'b1, 1'b0, 0,      0,      0,      0,      0, 1'b0},
    '{ACT_STEP,       0,      0,     0, 1'b0, 1'b0, 0,      0,      0,      0,      0, 1'b0},
    '{ACT_STEP,   21845, -21846, 10922, 1'b1, 1'b0, 0,      0,      0,      0,      0, 1'b0},
    '{ACT_START, -32768,  32767, 16383, 1'b1, 1'b1, 2, -16385,  32767, -49151,  32767, 1'b0},
    '{ACT_STEP,       0,      0,     0, 1'b0, 1'b0, 0,      0,      0,      0,      0, 1'b0},
    '{ACT_STEP,  -21846,  21845,  5461, 1'b0, 1'b0, 0,      0,      0,      0,      0, 1'b0},
    '{ACT_START,     10,     -5,     1, 1'b0, 1'b0, 0,      0,      0,      0,      0, 1'b0},
    '{ACT_STEP,       0,      0,     0, 1'b0, 1'b0, 0,      0,      0,      0,      0, 1'b0},
    '{ACT_STEP,       0,      0,     0, 1'b0, 1'b1, 0,      0,      0,      0,      0, 1'b0},
    '{ACT_START,   -100,    200,     5, 1'b1, 1'b0, 0,      0,      0,      0,      0, 1'b0},
    '{ACT_STEP,       0,      0,     0, 1'b0, 1'b0, 0,      0,      0,      0,      0, 1'b0},
    '{ACT_STEP,       0,      0,     0, 1'b1, 1'b0, 0,      0,      0,      0,      0, 1'b0},
    '{ACT_STEP,       0,      0,     0, 1'b0, 1'b0, 0,      0,      0,      0,      0, 1'b0},
    '{ACT_STEP,       0,      0,     0, 1'b1, 1'b0, 0,      0,      0,      0,      0, 1'b0},
    '{ACT_STEP,       0,      0,     0, 1'b0, 1'b1, 0,      0,      0,      0,      0, 1'b0},
    '{ACT_START,      3,      3,     3, 1'b0, 1'b0, 0,      0,      0,      0,      0, 1'b0},
    '{ACT_STEP,       0,      0,     0, 1'b0, 1'b0, 0,      0,      0,      0,      0, 1'b0},
    '{ACT_START,     -7,      9,     2, 1'b0, 1'b0, 0,      0,      0,      0,      0, 1'b0},
    '{ACT_STEP,       0,      0,     0, 1'b0, 1'b0, 0,      0,      0,      0,      0, 1'b0},
    '{ACT_STEP,       0,      0,     0, 1'b0, 1'b0, 0,      0,      0,      0,      0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  mcg_in_if  #(.COORD_BITS(CW), .RADIUS_BITS(RW)) cmd_ch ();
  mcg_out_if #(.COORD_BITS(CW))                   pix_ch ();

  midpoint_circle_generator #(.COORD_BITS(CW), .RADIUS_BITS(RW)) u_top (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd_ch),
    .pixel (pix_ch)
  );

  // Rasterizer state, mirrored from the block.
  bit arc_on;
  bit arc_fill;
  int arc_cx;
  int arc_cy;
  int arc_x;
  int arc_y;
  int arc_dec;
  int arc_ddx;
  int arc_ddy;

  pix_t fresh[$];
  pix_t pending[$];

  int  n_err;
  int  n_pix;
  int  n_items;
  int  n_cmd;
  int  n_start;
  int  n_idle;
  int  quiet;
  bit  drive_burst;
  bit  sink_burst;

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic report(input string what);
    n_err++;
    if (n_err <= PRINT_LIMIT) begin
      $display("mismatch at %0t: %s", $realtime, what);
    end
  endtask

  function automatic void put(input int xs, input int ys, input int xe, input int ye,
                              input bit done);
    pix_t p;
    p.xs   = xs[CW:0];
    p.ys   = ys[CW:0];
    p.xe   = xe[CW:0];
    p.ye   = ye[CW:0];
    p.last = 1'b0;
    p.done = done;
    fresh.push_back(p);
  endfunction

  // Works out the pixels or spans that one accepted command produces, in output order.
  function automatic void rasterize(input cmd_t c);
    int r;
    int x;
    int y;
    int cx;
    int cy;
    bit done;
    fresh.delete();
    if (c.action == ACT_START) begin
      r        = int'(c.r);
      arc_cx   = int'(c.cx);
      arc_cy   = int'(c.cy);
      arc_fill = c.fill;
      arc_x    = 0;
      arc_y    = r;
      arc_dec  = 1 - r;
      arc_ddx  = 0;
      arc_ddy  = -2 * r;
      arc_on   = (r > 0);
      done     = !arc_on;
      cx       = arc_cx;
      cy       = arc_cy;
      if (arc_fill) begin
        put(cx + r, cy, cx - r, cy, done);
        put(cx, cy + r, cx, cy - r, done);
      end else begin
        put(cx + r, cy, cx + r, cy, done);
        put(cx - r, cy, cx - r, cy, done);
        put(cx, cy + r, cx, cy + r, done);
        put(cx, cy - r, cx, cy - r, done);
      end
    end else begin
      if (!arc_on) begin
        return;
      end
      // The y step is taken only for a strictly positive decision term.
      if (arc_dec > 0) begin
        arc_y   -= 1;
        arc_ddy += 2;
        arc_dec += arc_ddy;
      end
      arc_x   += 1;
      arc_ddx += 2;
      arc_dec += arc_ddx + 1;
      if (arc_x >= arc_y) begin
        arc_on = 1'b0;
      end
      done = !arc_on;
      cx   = arc_cx;
      cy   = arc_cy;
      x    = arc_x;
      y    = arc_y;
      if (arc_fill) begin
        put(cx + x, cy + y, cx - x, cy + y, done);
        put(cx + x, cy - y, cx - x, cy - y, done);
        put(cx - y, cy - x, cx + y, cy - x, done);
        put(cx - y, cy + x, cx + y, cy + x, done);
      end else begin
        put(cx + x, cy + y, cx + x, cy + y, done);
        put(cx - x, cy + y, cx - x, cy + y, done);
        put(cx + x, cy - y, cx + x, cy - y, done);
        put(cx - x, cy - y, cx - x, cy - y, done);
        put(cx - y, cy - x, cx - y, cy - x, done);
        put(cx + y, cy - x, cx + y, cy - x, done);
        put(cx - y, cy + x, cx - y, cy + x, done);
        put(cx + y, cy + x, cx + y, cy + x, done);
      end
    end
    fresh[fresh.size() - 1].last = 1'b1;
  endfunction

  function automatic cmd_t rand_cmd(input logic action);
    cmd_t c;
    c.action = action;
    c.cx     = CW'($urandom);
    c.cy     = CW'($urandom);
    c.r      = RW'($urandom);
    c.fill   = 1'($urandom);
    return c;
  endfunction

  // Drives one command, waits for its transaction and queues what it should produce.
  task automatic issue(input cmd_t c, input bit typed = 1'b0, input int n = 0,
                       input pix_t first = '{default: 0});
    int gap;
    gap = drive_burst ? 0 : $urandom_range(0, 9);
    for (int i = 0; i < gap; i++) begin
      @(negedge clk);
      cmd_ch.valid <= 1'b0;
    end
    @(negedge clk);
    cmd_ch.valid    <= 1'b1;
    cmd_ch.action   <= c.action;
    cmd_ch.center_x <= c.cx;
    cmd_ch.center_y <= c.cy;
    cmd_ch.radius   <= c.r;
    cmd_ch.fill     <= c.fill;
    do @(posedge clk); while (!(cmd_ch.valid && cmd_ch.ready));
    rasterize(c);
    if (typed) begin
      if (fresh.size() != n) begin
        report($sformatf("command %0d: %0d results planned, %0d predicted",
                         n_cmd, n, fresh.size()));
      end
      if (n > 0 && fresh.size() > 0) begin
        first.last = fresh[0].last;
        fresh[0]   = first;
      end
    end
    n_cmd++;
    if (c.action == ACT_START) begin
      n_start++;
    end
    if (fresh.size() == 0) begin
      n_idle++;
    end else begin
      n_items++;
    end
    foreach (fresh[i]) begin
      pending.push_back(fresh[i]);
    end
  endtask

  // Result receiver with random back-pressure.
  initial begin
    int gap;
    pix_ch.ready = 1'b0;
    wait (!rst);
    forever begin
      if ($urandom_range(0, 39) == 0) begin
        sink_burst = ($urandom_range(0, 2) == 0);
      end
      gap = sink_burst ? 0 : $urandom_range(0, 9);
      for (int i = 0; i < gap; i++) begin
        @(negedge clk);
        pix_ch.ready <= 1'b0;
      end
      @(negedge clk);
      pix_ch.ready <= 1'b1;
      do @(posedge clk); while (!(pix_ch.valid && pix_ch.ready));
    end
  end

  // Result checker and watchdog.
  always @(posedge clk) begin
    pix_t want;
    if (!rst) begin
      if ((cmd_ch.valid && cmd_ch.ready) || (pix_ch.valid && pix_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (pix_ch.valid && pix_ch.ready) begin
        n_pix++;
        if (pending.size() == 0) begin
          report($sformatf("unexpected result (%0d,%0d)-(%0d,%0d) last %0b done %0b",
                           pix_ch.x_start, pix_ch.y_start, pix_ch.x_end, pix_ch.y_end,
                           pix_ch.last_of_item, pix_ch.circle_done));
        end else begin
          want = pending.pop_front();
          if (pix_ch.x_start !== want.xs || pix_ch.y_start !== want.ys ||
              pix_ch.x_end !== want.xe || pix_ch.y_end !== want.ye ||
              pix_ch.last_of_item !== want.last || pix_ch.circle_done !== want.done) begin
            report($sformatf("result %0d: (%0d,%0d)-(%0d,%0d) %0b%0b vs (%0d,%0d)-(%0d,%0d) %0b%0b",
                             n_pix, pix_ch.x_start, pix_ch.y_start, pix_ch.x_end,
                             pix_ch.y_end, pix_ch.last_of_item, pix_ch.circle_done,
                             want.xs, want.ys, want.xe, want.ye, want.last, want.done));
          end
        end
      end
      if (quiet >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                 quiet, pending.size());
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  initial begin
    cmd_t c;
    pix_t p;
    int   pick;
    cmd_ch.valid    = 1'b0;
    cmd_ch.action   = ACT_START;
    cmd_ch.center_x = '0;
    cmd_ch.center_y = '0;
    cmd_ch.radius   = '0;
    cmd_ch.fill     = 1'b0;
    drive_burst     = 1'b0;
    sink_burst      = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      c.action = plan[i].action;
      c.cx     = plan[i].cx[CW-1:0];
      c.cy     = plan[i].cy[CW-1:0];
      c.r      = plan[i].r[RW-1:0];
      c.fill   = plan[i].fill;
      p.xs     = plan[i].xs[CW:0];
      p.ys     = plan[i].ys[CW:0];
      p.xe     = plan[i].xe[CW:0];
      p.ye     = plan[i].ye[CW:0];
      p.last   = 1'b0;
      p.done   = plan[i].done;
      issue(c, plan[i].typed, plan[i].n, p);
    end

    // Mostly whole circles with random content; a few stray commands and abandoned circles.
    while (n_cmd < ITEM_GOAL) begin
      if ($urandom_range(0, 99) < 10) begin
        issue(rand_cmd(1'($urandom_range(0, 1))));
      end else begin
        c    = rand_cmd(ACT_START);
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          c.r = '0;
        end else if (pick < 80) begin
          c.r = RW'($urandom_range(1, 40));
        end else if (pick < 90) begin
          c.r = RW'($urandom_range(41, 200));
        end else begin
          c.r = RW'($urandom_range(0, 16383));
        end
        issue(c);
        if (c.r <= 40 && $urandom_range(0, 3) != 0) begin
          while (arc_on) begin
            issue(rand_cmd(ACT_STEP));
          end
          repeat ($urandom_range(0, 2)) issue(rand_cmd(ACT_STEP));
        end else begin
          repeat ($urandom_range(1, 8)) issue(rand_cmd(ACT_STEP));
        end
      end
      if ($urandom_range(0, 7) == 0) begin
        drive_burst = ($urandom_range(0, 3) == 0);
      end
    end

    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (pending.size() != 0) begin
      @(posedge clk);
    end
    repeat (16) @(posedge clk);
    $display("summary: %0d commands (%0d circle starts, %0d steps with no circle running)",
             n_cmd, n_start, n_idle);
    $display("summary: %0d results checked, %0d mismatches", n_pix, n_err);
    if (n_err == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
